// ===== hdl/mrli_pkg.sv =====
// types, codes and constants for the motor rs/ld/lq identifier
// used by motor_rs_ld_lq_identifier and mrli_chk; no dependencies
package mrli_pkg;

  // stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 136;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  // datapath widths
  localparam int ACC_W  = 36;   // min_slope * tick period
  localparam int NUM_W  = 53;   // widest dividend
  localparam int DEN_W  = 30;   // widest divisor
  localparam int QUO_W  = 32;
  localparam int DIVC_W = 5;

  // scale factors
  localparam logic [31:0] RS_SCALE = 32'd1000000;
  localparam logic [31:0] NS_SCALE = 32'd1000000000;
  localparam int LD_LIM_SH = 11;
  localparam int LQ_LIM_SH = 13;
  localparam int LD_DEN_SH = 14;
  localparam int LQ_DEN_SH = 11;

  localparam logic [15:0] S16_MIN = 16'h8000;
  localparam logic [15:0] S16_MAX = 16'h7FFF;

  // result field positions in out_tdata
  localparam int OUT_PWM_BIT  = 32;
  localparam int OUT_PH_LO    = 33;
  localparam int OUT_PH_HI    = 36;
  localparam int OUT_DONE_BIT = 37;

  // register reset values
  localparam logic [15:0] ALIGN_V_RST   = 16'd3277;
  localparam logic [15:0] RS_V_RST      = 16'd3277;
  localparam logic [15:0] PULSE_V_RST   = 16'd6554;
  localparam logic [11:0] ALIGN_T_RST   = 12'd2000;
  localparam logic [11:0] SETTLE_T_RST  = 12'd2000;
  localparam logic [14:0] MIN_RS_I_RST  = 15'd51;
  localparam logic [15:0] MIN_SLOPE_RST = 16'd10;
  localparam logic [19:0] TICK_NS_RST   = 20'd50000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ALIGN_V   = 3'd0,
    CFG_RS_V      = 3'd1,
    CFG_PULSE_V   = 3'd2,
    CFG_ALIGN_T   = 3'd3,
    CFG_SETTLE_T  = 3'd4,
    CFG_MIN_RS_I  = 3'd5,
    CFG_MIN_SLOPE = 3'd6,
    CFG_TICK_NS   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ALIGN  = 4'd1,
    PH_RSVOLT = 4'd2,
    PH_SETTLE = 4'd3,
    PH_RSSAMP = 4'd4,
    PH_DPULSE = 4'd5,
    PH_QPULSE = 4'd6,
    PH_FINISH = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_RS   = 2'd1,
    OP_LD   = 2'd2,
    OP_LQ   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'd0,
    S_MUL_A   = 4'd1,
    S_MUL_B   = 4'd2,
    S_CMP     = 4'd3,
    S_MUL_C   = 4'd4,
    S_MUL_D   = 4'd5,
    S_DIV_CHK = 4'd6,
    S_DIV     = 4'd7,
    S_OUT     = 4'd8
  } seq_t;

endpackage

// ===== hdl/motor_rs_ld_lq_identifier.sv =====
// top level of the motor rs/ld/lq identifier: phase sequencer, shared multiplier
// and bit-serial divider; depends on mrli_pkg
//
// Identifies stator resistance (micro-ohms) and d/q inductance (nanohenries) one
// control tick per input transaction. in_tuser 0 restarts the sequence and clears
// the results, in_tuser 1 is a control tick. Each input transaction yields exactly
// one output transaction with the voltage commands, phase, done flag and results.
// A tick that computes nothing goes straight to the output; a tick that updates
// Rs, Ld or Lq runs the restoring divider (one quotient bit per cycle) behind
// the single shared 32x32 multiplier. A failed slope test or a saturating
// quotient skips the divider. in_tready is high only between items; an output
// transaction may still wait for out_tready while the next item is taken in.
module motor_rs_ld_lq_identifier import mrli_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // d_current, q_current, vbus
  input  logic                  in_tuser,   // kind
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // vd_command, vq_command, pwm_update,
                                            // phase, done_res, resistance,
                                            // d_inductance, q_inductance, pad
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [15:0] align_v_r, rs_v_r, pulse_v_r, min_slope_r;
  logic [11:0] align_t_r, settle_t_r;
  logic [14:0] min_rs_i_r;
  logic [19:0] tick_ns_r;

  // identification state
  phase_t      phase_r, phase_nxt;
  logic [11:0] cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [15:0] base_r, base_nxt;
  logic [15:0] samp_r, samp_nxt;
  logic [15:0] vd_r, vd_nxt;
  logic [15:0] vq_r, vq_nxt;
  logic        pwm_r, pwm_nxt;
  logic [31:0] res_r [3];

  // arithmetic job
  op_t              op_r, op_nxt;
  logic [16:0]      dpos_r, dpos_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [15:0]      bus_r;
  logic [ACC_W-1:0] acc_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [DIVC_W-1:0] div_cnt_r;

  // sequencer
  seq_t state_r, state_nxt;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // input fields
  logic        kind;
  logic [15:0] idc, iqc, bus;
  logic        accept;

  // tick logic intermediates
  logic [12:0] nt;
  logic [16:0] d_delta;
  logic [18:0] q_sum;
  logic        clr_res;
  logic [15:0] pv_neg;

  // datapath control
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  logic             acc_we, num_we, num_shl;
  logic [NUM_W-1:0] lim;
  logic             slope_ok;
  logic             sat;
  logic [DEN_W+1:0] trial;
  logic             qbit;
  logic             res_we;
  logic [31:0]      res_val;
  logic [1:0]       res_idx;
  logic             out_load;
  logic [14:0]      rsv_pos, pv_pos;

  assign kind   = in_tuser;
  assign idc    = in_tdata[15:0];
  assign iqc    = in_tdata[31:16];
  assign bus    = in_tdata[47:32];
  assign accept = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_v_r   <= ALIGN_V_RST;
      rs_v_r      <= RS_V_RST;
      pulse_v_r   <= PULSE_V_RST;
      align_t_r   <= ALIGN_T_RST;
      settle_t_r  <= SETTLE_T_RST;
      min_rs_i_r  <= MIN_RS_I_RST;
      min_slope_r <= MIN_SLOPE_RST;
      tick_ns_r   <= TICK_NS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ALIGN_V:   align_v_r   <= cfg_wdata[15:0];
        CFG_RS_V:      rs_v_r      <= cfg_wdata[15:0];
        CFG_PULSE_V:   pulse_v_r   <= cfg_wdata[15:0];
        CFG_ALIGN_T:   align_t_r   <= cfg_wdata[11:0];
        CFG_SETTLE_T:  settle_t_r  <= cfg_wdata[11:0];
        CFG_MIN_RS_I:  min_rs_i_r  <= cfg_wdata[14:0];
        CFG_MIN_SLOPE: min_slope_r <= cfg_wdata[15:0];
        CFG_TICK_NS:   tick_ns_r   <= cfg_wdata[19:0];
      endcase
    end
  end

  // phase update for one transaction
  always_comb begin
    nt       = {1'b0, cnt_r} + 13'd1;
    d_delta  = {idc[15], idc} - {base_r[15], base_r};
    q_sum    = {{3{samp_r[15]}}, samp_r} + {{3{iqc[15]}}, iqc}
             - {{2{base_r[15]}}, base_r, 1'b0};
    pv_neg   = (pulse_v_r == S16_MIN) ? S16_MAX : 16'(-pulse_v_r);
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    base_nxt  = base_r;
    samp_nxt  = samp_r;
    vd_nxt    = vd_r;
    vq_nxt    = vq_r;
    pwm_nxt   = 1'b0;
    op_nxt    = OP_NONE;
    dpos_nxt  = dpos_r;
    den_nxt   = den_r;
    clr_res   = 1'b0;
    if (!kind) begin
      phase_nxt = PH_ALIGN;
      cnt_nxt   = '0;
      done_nxt  = 1'b0;
      clr_res   = 1'b1;
    end else if (!done_r && phase_r >= PH_ALIGN && phase_r <= PH_FINISH) begin
      pwm_nxt = 1'b1;
      cnt_nxt = nt[11:0];
      unique case (phase_r)
        PH_ALIGN: begin
          vd_nxt = align_v_r;
          vq_nxt = '0;
          if (nt > {1'b0, align_t_r}) begin
            cnt_nxt   = '0;
            phase_nxt = PH_RSVOLT;
          end
        end
        PH_RSVOLT: begin
          vd_nxt    = rs_v_r;
          vq_nxt    = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_SETTLE;
        end
        PH_SETTLE: begin
          vd_nxt = rs_v_r;
          vq_nxt = '0;
          if (nt > {1'b0, settle_t_r}) begin
            cnt_nxt   = '0;
            phase_nxt = PH_RSSAMP;
          end
        end
        PH_RSSAMP: begin
          vd_nxt   = rs_v_r;
          vq_nxt   = '0;
          samp_nxt = idc;
          if ($signed(idc) > $signed({1'b0, min_rs_i_r})) begin
            op_nxt  = OP_RS;
            den_nxt = {1'b0, idc[14:0], 14'b0};
          end
          cnt_nxt   = '0;
          phase_nxt = PH_DPULSE;
        end
        PH_DPULSE: begin
          vd_nxt = pulse_v_r;
          vq_nxt = '0;
          if (nt == 13'd1) begin
            base_nxt = idc;
          end else if (nt != 13'd2) begin
            samp_nxt = idc;
            // a slope that is not positive can never pass the test
            if (!d_delta[16] && d_delta != '0) begin
              op_nxt   = OP_LD;
              dpos_nxt = {1'b0, d_delta[15:0]};
              den_nxt  = {d_delta[15:0], LD_DEN_SH'(0)};
            end
            cnt_nxt   = '0;
            phase_nxt = PH_QPULSE;
          end
        end
        PH_QPULSE: begin
          if (nt == 13'd1) begin
            base_nxt = iqc;
            vq_nxt   = pulse_v_r;
          end else if (nt == 13'd3) begin
            samp_nxt = iqc;
            vq_nxt   = pv_neg;
          end else if (nt >= 13'd5) begin
            if (!q_sum[18] && q_sum != '0) begin
              op_nxt   = OP_LQ;
              dpos_nxt = q_sum[16:0];
              den_nxt  = {2'b0, q_sum[16:0], LQ_DEN_SH'(0)};
            end
            cnt_nxt   = '0;
            phase_nxt = PH_FINISH;
          end
        end
        default: begin
          vd_nxt    = '0;
          vq_nxt    = '0;
          done_nxt  = 1'b1;
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (accept) state_nxt = (op_nxt == OP_NONE) ? S_OUT : S_MUL_A;
      S_MUL_A:   state_nxt = S_MUL_B;
      S_MUL_B:   state_nxt = (op_r == OP_RS) ? S_DIV_CHK : S_CMP;
      S_CMP:     state_nxt = slope_ok ? S_MUL_C : S_OUT;
      S_MUL_C:   state_nxt = S_MUL_D;
      S_MUL_D:   state_nxt = S_DIV_CHK;
      S_DIV_CHK: state_nxt = sat ? S_OUT : S_DIV;
      S_DIV:     if (div_cnt_r == DIVC_W'(QUO_W - 1)) state_nxt = S_OUT;
      S_OUT:     if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // positive parts of the voltage registers; a non-positive one yields zero
  assign rsv_pos = rs_v_r[15]    ? '0 : rs_v_r[14:0];
  assign pv_pos  = pulse_v_r[15] ? '0 : pulse_v_r[14:0];

  // shared multiplier
  assign prod = mul_a * mul_b;

  // slope limit and saturation test
  assign lim      = (op_r == OP_LD) ? (NUM_W'(acc_r) << LD_LIM_SH)
                                    : (NUM_W'(acc_r) << LQ_LIM_SH);
  assign slope_ok = num_r > lim;
  assign sat      = DEN_W'(num_r[NUM_W-1:QUO_W]) >= den_r;

  // one restoring divider step
  assign trial = {1'b0, rem_r, quo_r[QUO_W-1]} - {2'b0, den_r};
  assign qbit  = !trial[DEN_W+1];

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    acc_we    = 1'b0;
    num_we    = 1'b0;
    num_shl   = 1'b0;
    res_we    = 1'b0;
    res_val   = '0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_MUL_A: begin
        acc_we = 1'b1;
        if (op_r == OP_RS) begin
          mul_a = 32'(rsv_pos);
          mul_b = 32'(bus_r);
        end else begin
          mul_a = 32'(min_slope_r);
          mul_b = 32'(tick_ns_r);
        end
      end
      S_MUL_B: begin
        num_we = 1'b1;
        if (op_r == OP_RS) begin
          mul_a = acc_r[31:0];
          mul_b = RS_SCALE;
        end else begin
          mul_a = 32'(dpos_r);
          mul_b = NS_SCALE;
        end
      end
      S_MUL_C: begin
        acc_we = 1'b1;
        mul_a  = 32'(pv_pos);
        mul_b  = 32'(bus_r);
      end
      S_MUL_D: begin
        num_we  = 1'b1;
        num_shl = (op_r == OP_LD);
        mul_a   = acc_r[31:0];
        mul_b   = 32'(tick_ns_r);
      end
      S_DIV_CHK: begin
        res_we  = sat;
        res_val = '1;
      end
      S_DIV: begin
        res_we  = (div_cnt_r == DIVC_W'(QUO_W - 1));
        res_val = {quo_r[QUO_W-2:0], qbit};
      end
      S_OUT: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_comb begin
    unique case (op_r)
      OP_LD:   res_idx = 2'd1;
      OP_LQ:   res_idx = 2'd2;
      default: res_idx = 2'd0;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
      base_r  <= '0;
      samp_r  <= '0;
      vd_r    <= '0;
      vq_r    <= '0;
      pwm_r   <= 1'b0;
      op_r    <= OP_NONE;
      for (int i = 0; i < 3; i++) res_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        done_r  <= done_nxt;
        base_r  <= base_nxt;
        samp_r  <= samp_nxt;
        vd_r    <= vd_nxt;
        vq_r    <= vq_nxt;
        pwm_r   <= pwm_nxt;
        op_r    <= op_nxt;
      end
      if (accept && clr_res) begin
        for (int i = 0; i < 3; i++) res_r[i] <= '0;
      end else if (res_we) begin
        res_r[res_idx] <= res_val;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dpos_r <= dpos_nxt;
      den_r  <= den_nxt;
      bus_r  <= bus;
    end
    if (acc_we) acc_r <= prod[ACC_W-1:0];
    if (num_we) num_r <= num_shl ? {prod[NUM_W-2:0], 1'b0} : prod[NUM_W-1:0];
    if (state_r == S_DIV_CHK) begin
      rem_r     <= DEN_W'(num_r[NUM_W-1:QUO_W]);
      quo_r     <= num_r[QUO_W-1:0];
      div_cnt_r <= '0;
    end else if (state_r == S_DIV) begin
      rem_r     <= qbit ? trial[DEN_W-1:0] : {rem_r[DEN_W-2:0], quo_r[QUO_W-1]};
      quo_r     <= {quo_r[QUO_W-2:0], qbit};
      div_cnt_r <= div_cnt_r + DIVC_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {2'b0, res_r[2], res_r[1], res_r[0], done_r, phase_r, pwm_r, vq_r, vd_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/mrli_chk.sv =====
// port-level checker for motor_rs_ld_lq_identifier, attached by bind
// depends on mrli_pkg
module mrli_chk import mrli_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: no input transaction right after another
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is at work");

  // done flag only together with the done phase
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DONE_BIT] |->
      out_tdata[OUT_PH_HI:OUT_PH_LO] == PH_DONE)
    else $error("done flag outside the done phase");

  // the modulator is never updated from idle
  a_pwm_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_PWM_BIT] |->
      out_tdata[OUT_PH_HI:OUT_PH_LO] != PH_IDLE)
    else $error("pwm update while idle");

endmodule

bind motor_rs_ld_lq_identifier mrli_chk u_mrli_chk (.*);
